FILE: src/srle_pkg.sv
// shared types and constants for the sun raster rle decoder
// no dependencies

package srle_pkg;

   localparam int SIZE_BITS_DEF = 24;
   localparam logic [7:0] RLE_FLAG = 8'h80;
   localparam int LEN_BITS = 9;
   localparam int TDATA_BITS = 24;

   typedef enum logic [1:0] {
      PH_FLAG  = 2'd0,
      PH_COUNT = 2'd1,
      PH_VALUE = 2'd2
   } phase_type;

   typedef struct packed {
      logic                valid;
      logic [7:0]          value;
      logic [LEN_BITS-1:0] length;
      logic                complete;
   } run_type;

endpackage

FILE: src/srle_in_stage.sv
// input register for encoded bytes and the start-of-image flag
// depends on srle_pkg

module srle_in_stage
   import srle_pkg::*;
(
   input  logic       clock,
   input  logic       reset,
   input  logic       req_tvalid,
   output logic       req_tready,
   input  logic [7:0] req_tdata,
   input  logic       req_tuser,
   input  logic       advance,
   output logic       item_valid,
   output logic [7:0] item_byte,
   output logic       item_sof
);

   logic       valid_ff, valid_in;
   logic [7:0] byte_ff;
   logic       sof_ff;
   logic       take;

   assign req_tready = !valid_ff || advance;
   assign take       = req_tvalid && req_tready;

   always_comb begin
      valid_in = valid_ff;
      if (take) begin
         valid_in = 1'b1;
      end else if (advance) begin
         valid_in = 1'b0;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         valid_ff <= 1'b0;
      end else begin
         valid_ff <= valid_in;
      end
   end

   always_ff @(posedge clock) begin
      if (take) begin
         byte_ff <= req_tdata;
         sof_ff  <= req_tuser;
      end
   end

   assign item_valid = valid_ff;
   assign item_byte  = byte_ff;
   assign item_sof   = sof_ff;

endmodule

FILE: src/srle_core.sv
// token parser and run clip: phase, pending count and written byte total
// depends on srle_pkg

module srle_core
   import srle_pkg::*;
#(
   parameter int SIZE_BITS = SIZE_BITS_DEF
)
(
   input  logic               clock,
   input  logic               reset,
   input  logic               fire,
   input  logic [7:0]         item_byte,
   input  logic               item_sof,
   input  logic [SIZE_BITS:0] image_size,
   output run_type            run
);

   localparam int W = SIZE_BITS + 1;

   phase_type           phase_ff, phase_in, phase_eff;
   logic [7:0]          held_ff, held_in, held_eff;
   logic [W-1:0]        written_ff, written_in, written_eff;
   logic                full;
   logic                emit;
   logic [7:0]          value;
   logic [LEN_BITS-1:0] len;
   logic [LEN_BITS-1:0] clipped;
   logic [W-1:0]        left;
   logic [W-1:0]        new_written;

   assign phase_eff   = item_sof ? PH_FLAG : phase_ff;
   assign held_eff    = item_sof ? 8'd0 : held_ff;
   assign written_eff = item_sof ? '0 : written_ff;
   assign full        = written_eff >= image_size;

   // next state
   always_comb begin
      phase_in = phase_eff;
      held_in  = held_eff;
      if (!full) begin
         case (phase_eff)
            PH_COUNT: begin
               if (item_byte == 8'd0) begin
                  phase_in = PH_FLAG;
               end else begin
                  phase_in = PH_VALUE;
                  held_in  = item_byte;
               end
            end
            PH_VALUE: begin
               phase_in = PH_FLAG;
            end
            default: begin
               phase_in = (item_byte == RLE_FLAG) ? PH_COUNT : PH_FLAG;
            end
         endcase
      end
   end

   // outputs
   always_comb begin
      emit  = 1'b0;
      value = item_byte;
      len   = LEN_BITS'(1);
      case (phase_eff)
         PH_COUNT: begin
            emit  = (item_byte == 8'd0);
            value = RLE_FLAG;
         end
         PH_VALUE: begin
            emit = 1'b1;
            len  = {1'b0, held_eff} + LEN_BITS'(1);
         end
         default: begin
            emit = (item_byte != RLE_FLAG);
         end
      endcase
      emit = emit && !full;
   end

   assign left        = image_size - written_eff;
   assign clipped     = (W'(len) > left) ? left[LEN_BITS-1:0] : len;
   assign new_written = written_eff + W'(clipped);
   assign written_in  = emit ? new_written : written_eff;

   always_ff @(posedge clock) begin
      if (reset) begin
         phase_ff   <= PH_FLAG;
         held_ff    <= 8'd0;
         written_ff <= '0;
      end else if (fire) begin
         phase_ff   <= phase_in;
         held_ff    <= held_in;
         written_ff <= written_in;
      end
   end

   assign run.valid    = emit;
   assign run.value    = value;
   assign run.length   = clipped;
   assign run.complete = (new_written == image_size);

endmodule

FILE: src/srle_out_stage.sv
// result register holding one decoded run until the sink takes it
// depends on srle_pkg

module srle_out_stage
   import srle_pkg::*;
(
   input  logic                  clock,
   input  logic                  reset,
   input  logic                  advance,
   input  run_type               run,
   output logic                  out_busy,
   output logic                  rsp_tvalid,
   input  logic                  rsp_tready,
   output logic [TDATA_BITS-1:0] rsp_tdata,
   output logic                  rsp_tlast
);

   logic                valid_ff, valid_in;
   logic [7:0]          value_ff;
   logic [LEN_BITS-1:0] length_ff;
   logic                last_ff;
   logic                load;

   assign load = advance && run.valid;

   always_comb begin
      valid_in = valid_ff;
      if (load) begin
         valid_in = 1'b1;
      end else if (rsp_tready) begin
         valid_in = 1'b0;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         valid_ff <= 1'b0;
      end else begin
         valid_ff <= valid_in;
      end
   end

   always_ff @(posedge clock) begin
      if (load) begin
         value_ff  <= run.value;
         length_ff <= run.length;
         last_ff   <= run.complete;
      end
   end

   assign out_busy   = valid_ff && !rsp_tready;
   assign rsp_tvalid = valid_ff;
   assign rsp_tdata  = {(TDATA_BITS - LEN_BITS - 8)'(0), length_ff, value_ff};
   assign rsp_tlast  = last_ff;

endmodule

FILE: src/sun_raster_rle_decoder.sv
// Sun raster byte-encoded image decoder: one encoded byte in per cycle, one
// run out per literal, escaped flag or counted run. An accepted byte is held in
// an input register, then parsed and clipped combinationally as it moves into
// the result register; one byte per cycle is sustained while the sink keeps
// rsp_tready high, a rate set by the loop through the written-byte total
// (subtract, compare, add).
// Bytes after the image is full give no run until one arrives with the
// start-of-image flag. The user must write image_size only while the decoder
// is idle; the decoder itself does not enforce this.
// depends on srle_pkg, srle_in_stage, srle_core, srle_out_stage

module sun_raster_rle_decoder
   import srle_pkg::*;
#(
   parameter int SIZE_BITS = SIZE_BITS_DEF
)
(
   input  logic                  clock,
   input  logic                  reset,
   input  logic                  req_tvalid,
   output logic                  req_tready,
   input  logic [7:0]            req_tdata,   // code_byte
   input  logic                  req_tuser,   // start_of_image
   output logic                  rsp_tvalid,
   input  logic                  rsp_tready,
   output logic [TDATA_BITS-1:0] rsp_tdata,   // run_value, run_length, zero pad
   output logic                  rsp_tlast,   // image_complete
   input  logic                  csr_we,
   input  logic [SIZE_BITS:0]    csr_wdata    // image_size
);

   logic [SIZE_BITS:0] size_ff;
   logic               item_valid;
   logic [7:0]         item_byte;
   logic               item_sof;
   logic               out_busy;
   logic               advance;
   run_type            run;

   always_ff @(posedge clock) begin
      if (reset) begin
         size_ff <= (SIZE_BITS + 1)'(1);
      end else if (csr_we) begin
         size_ff <= csr_wdata;
      end
   end

   assign advance = item_valid && !out_busy;

   srle_in_stage u_in (
      .clock      (clock),
      .reset      (reset),
      .req_tvalid (req_tvalid),
      .req_tready (req_tready),
      .req_tdata  (req_tdata),
      .req_tuser  (req_tuser),
      .advance    (advance),
      .item_valid (item_valid),
      .item_byte  (item_byte),
      .item_sof   (item_sof)
   );

   srle_core #(
      .SIZE_BITS (SIZE_BITS)
   ) u_core (
      .clock      (clock),
      .reset      (reset),
      .fire       (advance),
      .item_byte  (item_byte),
      .item_sof   (item_sof),
      .image_size (size_ff),
      .run        (run)
   );

   srle_out_stage u_out (
      .clock      (clock),
      .reset      (reset),
      .advance    (advance),
      .run        (run),
      .out_busy   (out_busy),
      .rsp_tvalid (rsp_tvalid),
      .rsp_tready (rsp_tready),
      .rsp_tdata  (rsp_tdata),
      .rsp_tlast  (rsp_tlast)
   );

endmodule
